FILE: rtl/rd_pkg.sv
// ----------------------------------------------------------------------------
// rd_pkg: shared definitions for the restoring divider
// Operand width, field width, round counter width and the control
// struct that the sequencer hands to the row of divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rd_pkg;

   // operand width of the divider datapath (2 to 63)
   localparam int WIDTH   = 32;
   // width of the request and response fields
   localparam int FIELD_W = 32;
   // round counter must hold WIDTH itself
   localparam int CNT_W   = $clog2(WIDTH + 1);
   // staging width for field/operand conversion
   localparam int MAX_W   = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

   // control from the sequencer to the cell row
   typedef struct packed {
      logic load;   // take new operands, clear partial remainder
      logic step;   // run one shift-subtract-restore round
   } rd_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/restoring_divider.sv
// ----------------------------------------------------------------------------
// restoring_divider: unsigned restoring divider, top level
// Sequencer, round counter and response register around the cell row.
// ----------------------------------------------------------------------------
// Divides req_dividend by req_divisor (both unsigned, low WIDTH bits used)
// and returns the quotient and remainder. A request runs WIDTH rounds
// through the row of bit-slice cells, one quotient bit per cycle, set by
// the borrow ripple along the row, and the result is then handed to the
// response register from ST_DONE. A new request is taken in that handoff
// cycle while the response side keeps up. A waiting response does not block
// the start of the next division, but holds its result in ST_DONE, with no
// new request taken, until the response slot frees. A zero divisor returns
// an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module restoring_divider
   import rd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FIELD_W-1:0] req_dividend,
   input  wire logic [FIELD_W-1:0] req_divisor,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [FIELD_W-1:0] rsp_quotient,
   output logic      [FIELD_W-1:0] rsp_remainder
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] rounds_left_ff, rounds_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_quotient_ff, rsp_quotient_in;
   logic [FIELD_W-1:0] rsp_remainder_ff, rsp_remainder_in;

   rd_ctl_type       ctl;
   logic             req_fire;
   logic             slot_free;
   logic [MAX_W-1:0] dividend_x;
   logic [MAX_W-1:0] divisor_x;
   logic [WIDTH-1:0] row_quotient;
   logic [WIDTH-1:0] row_remainder;

   // fit request fields to the operand width
   assign dividend_x = MAX_W'(req_dividend);
   assign divisor_x  = MAX_W'(req_divisor);

   // response slot can take a result this cycle
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) | ((state_ff == ST_DONE) & slot_free);
   assign req_fire  = req_valid & req_ready;

   assign ctl.load = req_fire;
   assign ctl.step = (state_ff == ST_RUN);

   // sequence rounds and hand results to the response register
   always_comb begin
      state_in         = state_ff;
      rounds_left_in   = rounds_left_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      rsp_quotient_in  = rsp_quotient_ff;
      rsp_remainder_in = rsp_remainder_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in       = ST_RUN;
               rounds_left_in = CNT_W'(WIDTH);
            end
         end
         ST_RUN: begin
            rounds_left_in = rounds_left_ff - 1'b1;
            if (rounds_left_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_quotient_in  = FIELD_W'(row_quotient);
               rsp_remainder_in = FIELD_W'(row_remainder);
               state_in         = ST_IDLE;
               if (req_fire) begin
                  state_in       = ST_RUN;
                  rounds_left_in = CNT_W'(WIDTH);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rounds_left_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rounds_left_ff <= rounds_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_quotient_ff  <= rsp_quotient_in;
      rsp_remainder_ff <= rsp_remainder_in;
   end

   rd_row u_row (
      .clock       (clock),
      .ctl         (ctl),
      .ld_dividend (dividend_x[WIDTH-1:0]),
      .ld_divisor  (divisor_x[WIDTH-1:0]),
      .quotient    (row_quotient),
      .remainder   (row_remainder)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quotient  = rsp_quotient_ff;
   assign rsp_remainder = rsp_remainder_ff;

endmodule

`default_nettype wire

FILE: rtl/rd_cell.sv
// ----------------------------------------------------------------------------
// rd_cell: one bit slice of the divider
// Holds one bit each of partial remainder, quotient and divisor. Each round
// it takes the shifted-in bits from its lower neighbor, forms its bit of the
// trial difference and passes the borrow up the row.
// ----------------------------------------------------------------------------
`default_nettype none

module rd_cell
   import rd_pkg::*;
(
   input  wire logic       clock,
   input  wire rd_ctl_type ctl,
   input  wire logic       ld_q,        // dividend bit on load
   input  wire logic       ld_d,        // divisor bit on load
   input  wire logic       pr_sin,      // remainder bit shifted in from below
   input  wire logic       q_sin,       // quotient bit shifted in from below
   input  wire logic       borrow_in,   // borrow from the lower slice
   input  wire logic       take,        // trial subtraction succeeded
   output logic            borrow_out,
   output logic            pr,
   output logic            q
);

   logic pr_ff, pr_in;
   logic q_ff,  q_in;
   logic d_ff,  d_in;
   logic diff;

   // trial subtract of the divisor bit from the shifted remainder bit
   assign diff       = pr_sin ^ d_ff ^ borrow_in;
   assign borrow_out = (~pr_sin & d_ff) | (~(pr_sin ^ d_ff) & borrow_in);

   // load, advance one round, or hold
   always_comb begin
      pr_in = pr_ff;
      q_in  = q_ff;
      d_in  = d_ff;
      if (ctl.load) begin
         pr_in = 1'b0;
         q_in  = ld_q;
         d_in  = ld_d;
      end else if (ctl.step) begin
         pr_in = take ? diff : pr_sin;
         q_in  = q_sin;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff <= pr_in;
      q_ff  <= q_in;
      d_ff  <= d_in;
   end

   assign pr = pr_ff;
   assign q  = q_ff;

endmodule

`default_nettype wire

FILE: rtl/rd_row.sv
// ----------------------------------------------------------------------------
// rd_row: row of WIDTH divider cells
// Chains the bit slices: remainder and quotient shift left one slice per
// round, the borrow ripples upward, and the top of the chain decides
// whether the difference is kept or the remainder restored.
// ----------------------------------------------------------------------------
`default_nettype none

module rd_row
   import rd_pkg::*;
(
   input  wire logic             clock,
   input  wire rd_ctl_type       ctl,
   input  wire logic [WIDTH-1:0] ld_dividend,
   input  wire logic [WIDTH-1:0] ld_divisor,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder
);

   logic [WIDTH-1:0] pr_w;
   logic [WIDTH-1:0] q_w;
   logic [WIDTH-1:0] borrow_w;
   logic [WIDTH-1:0] pr_sin_w;
   logic [WIDTH-1:0] q_sin_w;
   logic [WIDTH-1:0] bin_w;
   logic             s_top;
   logic             take;

   // shift paths: quotient top bit feeds the remainder bottom
   assign pr_sin_w = {pr_w[WIDTH-2:0], q_w[WIDTH-1]};
   assign q_sin_w  = {q_w[WIDTH-2:0], take};
   assign bin_w    = {borrow_w[WIDTH-2:0], 1'b0};

   // top remainder bit after the shift; the divisor has no bit here, and
   // the stored remainder stays below the divisor, so no register is kept
   assign s_top = pr_w[WIDTH-1];
   assign take  = s_top | ~borrow_w[WIDTH-1];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      rd_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ld_q       (ld_dividend[i]),
         .ld_d       (ld_divisor[i]),
         .pr_sin     (pr_sin_w[i]),
         .q_sin      (q_sin_w[i]),
         .borrow_in  (bin_w[i]),
         .take       (take),
         .borrow_out (borrow_w[i]),
         .pr         (pr_w[i]),
         .q          (q_w[i])
      );
   end

   assign quotient  = q_w;
   assign remainder = pr_w;

endmodule

`default_nettype wire

FILE: rtl/rd_checker.sv
// ----------------------------------------------------------------------------
// rd_checker: port-level checks for the restoring divider
// Watches the top-level ports for response stability, reset behavior and
// the spacing of accepted requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rd_checker
   import rd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [FIELD_W-1:0] req_dividend,
   input wire logic [FIELD_W-1:0] req_divisor,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [FIELD_W-1:0] rsp_quotient,
   input wire logic [FIELD_W-1:0] rsp_remainder
);

   logic req_fire;
   logic req_fields_known;

   assign req_fire         = req_valid & req_ready;
   assign req_fields_known = ^{req_dividend, req_divisor} !== 1'bx;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
                                  && $stable(rsp_remainder))
      else $error("response changed while stalled");

   // reset leaves no response and an open request port
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // an accepted request blocks the port on the next cycle
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while dividing");

   // the port is still closed in the last round
   a_busy_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_fields_known |-> ##WIDTH !req_ready)
      else $error("request port reopened before the last round");

endmodule

bind restoring_divider rd_checker u_rd_checker (.*);

`default_nettype wire
